// ----- rtl/ttll_pkg.sv -----
// Shared constants, codes and control structs for the threshold table lookup.
package ttll_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int VALUE_BITS  = 32;
   localparam int PTS_BITS    = 11;

   localparam logic [1:0] ACT_WR_ENERGY = 2'd0;
   localparam logic [1:0] ACT_WR_VALUE  = 2'd1;
   localparam logic [1:0] ACT_QUERY     = 2'd2;
   localparam logic [1:0] ACT_UNUSED    = 2'd3;

   localparam logic [1:0] REG_BELOW  = 2'd0;
   localparam logic [1:0] REG_INTERP = 2'd1;
   localparam logic [1:0] REG_AT_TOP = 2'd2;
   localparam logic [1:0] REG_ABOVE  = 2'd3;

   localparam logic CSR_POINTS    = 1'b0;
   localparam logic CSR_THRESHOLD = 1'b1;

   // datapath commands
   localparam logic [3:0] CMD_NONE     = 4'd0;
   localparam logic [3:0] CMD_WR_E     = 4'd1;
   localparam logic [3:0] CMD_WR_V     = 4'd2;
   localparam logic [3:0] CMD_START    = 4'd3;
   localparam logic [3:0] CMD_RD_THR   = 4'd4;
   localparam logic [3:0] CMD_RD_TOP   = 4'd5;
   localparam logic [3:0] CMD_CHECK    = 4'd6;
   localparam logic [3:0] CMD_TAKE_TOP = 4'd7;
   localparam logic [3:0] CMD_SEARCH   = 4'd8;
   localparam logic [3:0] CMD_COMPARE  = 4'd9;
   localparam logic [3:0] CMD_RD_HI    = 4'd10;
   localparam logic [3:0] CMD_PREP     = 4'd11;
   localparam logic [3:0] CMD_MULT     = 4'd12;
   localparam logic [3:0] CMD_DIV      = 4'd13;
   localparam logic [3:0] CMD_FIX      = 4'd14;
   localparam logic [3:0] CMD_LOAD     = 4'd15;

   typedef struct packed {
      logic [3:0] op;
   } ttll_cmd_type;

   typedef struct packed {
      logic below;
      logic in_range;
      logic at_top;
      logic search_done;
      logic out_free;
   } ttll_status_type;

endpackage

// ----- rtl/ttll_ctrl.sv -----
// Query sequencer: accepts words and steps the datapath through a lookup.
module ttll_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [1:0]                req_action,
   output logic                      req_stall,
   input  ttll_pkg::ttll_status_type status,
   output ttll_pkg::ttll_cmd_type    cmd
);
   import ttll_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RTHR = 4'd1;
   localparam logic [3:0] S_RTOP = 4'd2;
   localparam logic [3:0] S_CHK  = 4'd3;
   localparam logic [3:0] S_VTOP = 4'd4;
   localparam logic [3:0] S_SRCH = 4'd5;
   localparam logic [3:0] S_SCMP = 4'd6;
   localparam logic [3:0] S_RHI  = 4'd7;
   localparam logic [3:0] S_PREP = 4'd8;
   localparam logic [3:0] S_MULT = 4'd9;
   localparam logic [3:0] S_DIV  = 4'd10;
   localparam logic [3:0] S_FIX  = 4'd11;
   localparam logic [3:0] S_FIN  = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_action)
                  ACT_WR_ENERGY: cmd.op = CMD_WR_E;
                  ACT_WR_VALUE:  cmd.op = CMD_WR_V;
                  ACT_QUERY: begin
                     cmd.op   = CMD_START;
                     state_in = S_RTHR;
                  end
                  default: cmd.op = CMD_NONE;
               endcase
            end
         end
         S_RTHR: begin
            cmd.op   = CMD_RD_THR;
            state_in = S_RTOP;
         end
         S_RTOP: begin
            cmd.op   = CMD_RD_TOP;
            state_in = S_CHK;
         end
         S_CHK: begin
            cmd.op = CMD_CHECK;
            if (status.in_range) state_in = S_SRCH;
            else if (status.at_top) state_in = S_VTOP;
            else state_in = S_FIN;
         end
         S_VTOP: begin
            cmd.op   = CMD_TAKE_TOP;
            state_in = S_FIN;
         end
         S_SRCH: begin
            cmd.op   = CMD_SEARCH;
            state_in = status.search_done ? S_RHI : S_SCMP;
         end
         S_SCMP: begin
            cmd.op   = CMD_COMPARE;
            state_in = S_SRCH;
         end
         S_RHI: begin
            cmd.op   = CMD_RD_HI;
            state_in = S_PREP;
         end
         S_PREP: begin
            cmd.op   = CMD_PREP;
            state_in = S_MULT;
         end
         S_MULT: begin
            cmd.op   = CMD_MULT;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = CMD_DIV;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = S_FIX;
         end
         S_FIX: begin
            cmd.op   = CMD_FIX;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (status.out_free) begin
               cmd.op   = CMD_LOAD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- rtl/ttll_dpath.sv -----
// Tables, config registers, search bracket, multiply and serial divide, result word.
module ttll_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  ttll_pkg::ttll_cmd_type              cmd,
   output ttll_pkg::ttll_status_type           status,
   input  logic [ttll_pkg::ADDR_BITS-1:0]      req_entry_index,
   input  logic [31:0]                         req_operand_value,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ttll_pkg::VALUE_BITS-1:0]     rsp_looked_up_value,
   output logic [1:0]                          rsp_region
);
   import ttll_pkg::*;

   logic [31:0]           energy_mem [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] value_mem  [TABLE_DEPTH];

   logic [PTS_BITS-1:0]   points_ff;
   logic [ADDR_BITS-1:0]  thresh_ff;
   logic [PTS_BITS-1:0]   n_in;
   logic [ADDR_BITS-1:0]  nm2, t_in;
   logic [ADDR_BITS-1:0]  t_ff, top_ff;
   logic [31:0]           opv_ff, thr_ff, e_rd_ff, e0_ff, span_ff, dx_ff;
   logic [VALUE_BITS-1:0] v_rd_ff, y0_ff, mag_ff, res_ff;
   logic                  up_ff;
   logic [1:0]            region_ff;
   logic [ADDR_BITS-1:0]  lo_ff, hi_ff, mid, e_addr, v_addr;
   logic [63:0]           prod_ff;
   logic [32:0]           div_try;
   logic                  div_ge;
   logic                  rsp_valid_ff;
   logic [VALUE_BITS-1:0] out_val_ff;
   logic [1:0]            out_reg_ff;
   logic                  csr_wr;

   // clamp the configured counts as they are used
   always_comb begin
      if (points_ff < PTS_BITS'(2)) n_in = PTS_BITS'(2);
      else if (points_ff > PTS_BITS'(TABLE_DEPTH)) n_in = PTS_BITS'(TABLE_DEPTH);
      else n_in = points_ff;
      nm2  = ADDR_BITS'(n_in - PTS_BITS'(2));
      t_in = (thresh_ff > nm2) ? nm2 : thresh_ff;
   end

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_comb begin
      e_addr = lo_ff;
      v_addr = lo_ff - t_ff;
      case (cmd.op)
         CMD_RD_THR: e_addr = t_ff;
         CMD_RD_TOP: e_addr = top_ff;
         CMD_CHECK:  v_addr = top_ff - t_ff;
         CMD_SEARCH: e_addr = status.search_done ? lo_ff : mid;
         CMD_RD_HI: begin
            e_addr = lo_ff + ADDR_BITS'(1);
            v_addr = lo_ff + ADDR_BITS'(1) - t_ff;
         end
         default: e_addr = lo_ff;
      endcase
   end

   always_comb begin
      status.below       = opv_ff < thr_ff;
      status.in_range    = !(opv_ff < thr_ff) && (opv_ff < e_rd_ff);
      status.at_top      = !(opv_ff < thr_ff) && (opv_ff == e_rd_ff);
      status.search_done = (hi_ff - lo_ff) <= ADDR_BITS'(1);
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_WR_E) energy_mem[req_entry_index] <= req_operand_value;
      e_rd_ff <= energy_mem[e_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_WR_V) value_mem[req_entry_index] <= VALUE_BITS'(req_operand_value);
      v_rd_ff <= value_mem[v_addr];
   end

   assign div_try = {prod_ff[63:32], prod_ff[31]};
   assign div_ge  = div_try >= {1'b0, span_ff};

   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_START: begin
            opv_ff <= req_operand_value;
            t_ff   <= t_in;
            top_ff <= ADDR_BITS'(n_in - PTS_BITS'(1));
         end
         CMD_RD_TOP: thr_ff <= e_rd_ff;
         CMD_CHECK: begin
            lo_ff     <= t_ff;
            hi_ff     <= top_ff;
            res_ff    <= '0;
            if (status.below) region_ff <= REG_BELOW;
            else if (status.in_range) region_ff <= REG_INTERP;
            else if (status.at_top) region_ff <= REG_AT_TOP;
            else region_ff <= REG_ABOVE;
         end
         CMD_TAKE_TOP: res_ff <= v_rd_ff;
         CMD_COMPARE: begin
            if (e_rd_ff <= opv_ff) lo_ff <= mid;
            else hi_ff <= mid;
         end
         CMD_RD_HI: begin
            e0_ff <= e_rd_ff;
            y0_ff <= v_rd_ff;
         end
         CMD_PREP: begin
            span_ff <= e_rd_ff - e0_ff;
            dx_ff   <= opv_ff - e0_ff;
            up_ff   <= v_rd_ff >= y0_ff;
            mag_ff  <= (v_rd_ff >= y0_ff) ? v_rd_ff - y0_ff : y0_ff - v_rd_ff;
         end
         CMD_MULT: prod_ff <= 64'(mag_ff) * 64'(dx_ff);
         // restoring divide, one quotient bit per step into the low half
         CMD_DIV: begin
            prod_ff[63:32] <= div_ge ? 32'(div_try - {1'b0, span_ff}) : div_try[31:0];
            prod_ff[31:0]  <= {prod_ff[30:0], div_ge};
         end
         CMD_FIX: res_ff <= up_ff ? y0_ff + prod_ff[31:0] : y0_ff - prod_ff[31:0];
         default: res_ff <= res_ff;
      endcase
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == CMD_LOAD) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == CMD_LOAD) begin
         out_val_ff <= res_ff;
         out_reg_ff <= region_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_looked_up_value = out_val_ff;
   assign rsp_region          = out_reg_ff;

   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= PTS_BITS'(2);
         thresh_ff <= '0;
      end else if (csr_wr) begin
         if (csr_paddr[2] == CSR_POINTS) points_ff <= csr_pwdata[PTS_BITS-1:0];
         else thresh_ff <= csr_pwdata[ADDR_BITS-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_POINTS) ? 32'(points_ff) : 32'(thresh_ff);

endmodule

// ----- rtl/threshold_table_lerp_lookup_unit.sv -----
// Top level: threshold table lookup with binary search and linear interpolation.
//
//  channel  prefix  direction  word
//  request  req_    in         action, entry_index, operand_value
//  result   rsp_    out        looked_up_value, region
//  config   csr_    in/out     APB registers points_in_use (0x0), threshold_point (0x4)
//
// Writes are taken while idle and do not stall. A query reads the threshold and top
// entries and checks the region; it takes the top value at the top point, and an
// interpolation does one energy-table read per search step and a 32-step serial divide.
// Synchronous reset clears control and config; the tables hold garbage until written.
// A finished word waits in the output register; writes keep flowing meanwhile, and a
// later query holds in its last state until that register frees.
module threshold_table_lerp_lookup_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_action,
   input  logic [ttll_pkg::ADDR_BITS-1:0]  req_entry_index,
   input  logic [31:0]                     req_operand_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ttll_pkg::VALUE_BITS-1:0] rsp_looked_up_value,
   output logic [1:0]                      rsp_region,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [2:0]                      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import ttll_pkg::*;

   ttll_cmd_type    cmd;
   ttll_status_type status;

   assign csr_pready = 1'b1;

   ttll_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   ttll_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_entry_index     (req_entry_index),
      .req_operand_value   (req_operand_value),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_looked_up_value (rsp_looked_up_value),
      .rsp_region          (rsp_region)
   );

`ifndef SYNTH
   a_zero_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_region == REG_BELOW || rsp_region == REG_ABOVE)
         |-> rsp_looked_up_value == '0)
      else $error("nonzero value outside table range");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == CMD_LOAD |-> status.out_free)
      else $error("result loaded over a pending word");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("sequencer busy after reset");
`endif

endmodule
